// ===== design/page_table_mapper_with_frame_stack_core_macros.svh =====
// -----------------------------------------------------------------------------
// Assertion macros for the page table mapper
// Shared property wrappers used by the RTL assertion sections.
// -----------------------------------------------------------------------------
`ifndef PAGE_TABLE_MAPPER_WITH_FRAME_STACK_CORE_MACROS_SVH
`define PAGE_TABLE_MAPPER_WITH_FRAME_STACK_CORE_MACROS_SVH

// Check that a condition implies a consequence on the same edge.
`define PTM_ASSERT_IMPL(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// Check that a condition implies a consequence on the next edge.
`define PTM_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/ptm_pkg.sv =====
// -----------------------------------------------------------------------------
// ptm_pkg
// Constants, codes and types shared by the page table mapper files.
// -----------------------------------------------------------------------------
package ptm_pkg;

   localparam int STACK_DEPTH_DEF       = 256;
   localparam int MEM_FRAMES_DEF        = 256;
   localparam int ENTRIES_PER_TABLE_DEF = 512;

   localparam int ADDR_W  = 52;
   localparam int WORD_W  = 64;
   localparam int IDX_W   = 9;

   localparam logic [WORD_W-1:0] ADDR_FIELD = 64'h000F_FFFF_FFFF_F000;
   localparam logic [WORD_W-1:0] BIT_P      = 64'h1;
   localparam logic [WORD_W-1:0] BIT_RW     = 64'h2;
   localparam logic [WORD_W-1:0] CACHE_BITS = 64'h18;

   typedef enum logic [1:0] {
      KIND_FREE  = 2'd0,
      KIND_ALLOC = 2'd1,
      KIND_MAP   = 2'd2,
      KIND_READ  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_NO_FRAME  = 3'd2,
      ST_NO_L3     = 3'd3,
      ST_NO_L2     = 3'd4,
      ST_NO_L1     = 3'd5
   } status_type;

endpackage

// ===== design/ptm_ram.sv =====
// -----------------------------------------------------------------------------
// ptm_ram
// Generic single-port synchronous RAM with registered read data.
// -----------------------------------------------------------------------------
module ptm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  logic [WIDTH-1:0]                            wr_data,
   output logic [WIDTH-1:0]                            rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/page_table_mapper_with_frame_stack_core.sv =====
// -----------------------------------------------------------------------------
// Page table mapper with frame stack
// Free frame stack plus four-level page table walker over a modeled memory.
// -----------------------------------------------------------------------------
// One item is taken at a time; its single result beat then waits in an output
// register and the request side stalls until that beat leaves. Each upper level
// walked by a map takes an entry read, a wait and an update; each missing level
// also has its new table cleared one word a cycle over the one table memory port,
// and the link is then written again. After reset a clearing pass zeroes the
// table memory while no item is taken; CSR writes are accepted throughout.
module page_table_mapper_with_frame_stack_core #(
   parameter int STACK_DEPTH = ptm_pkg::STACK_DEPTH_DEF,
   parameter int MEM_FRAMES  = ptm_pkg::MEM_FRAMES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_kind,
   input  logic [ptm_pkg::ADDR_W-1:0] req_phys_addr,
   input  logic [ptm_pkg::WORD_W-1:0] req_virt_addr,
   input  logic [ptm_pkg::WORD_W-1:0] req_page_flags,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [2:0]                 rsp_status,
   output logic [ptm_pkg::ADDR_W-1:0] rsp_frame_out,
   output logic [ptm_pkg::WORD_W-1:0] rsp_read_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [ptm_pkg::ADDR_W-1:0] csr_root_table_addr
);
   import ptm_pkg::*;
`include "page_table_mapper_with_frame_stack_core_macros.svh"

   localparam int MEM_WORDS = MEM_FRAMES * ENTRIES_PER_TABLE_DEF;
   localparam int MA_W      = $clog2(MEM_WORDS);
   localparam int SP_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(STACK_DEPTH);

   typedef enum logic [10:0] {
      S_INIT   = 11'b00000000001,
      S_IDLE   = 11'b00000000010,
      S_POP    = 11'b00000000100,
      S_POPW   = 11'b00000001000,
      S_RDW    = 11'b00000010000,
      S_ELOOK  = 11'b00000100000,
      S_EWAIT  = 11'b00001000000,
      S_EDEC   = 11'b00010000000,
      S_CLEAR  = 11'b00100000000,
      S_LEAF   = 11'b01000000000,
      S_DONE   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration register.
   logic [ADDR_W-1:0] root_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff <= '0;
      end else if (csr_valid) begin
         root_ff <= csr_root_table_addr;
      end
   end

   // Held item.
   kind_type          kind_ff;
   logic [ADDR_W-1:0] pa_ff;
   logic [WORD_W-1:0] va_ff, flags_ff;
   logic [1:0]        lvl_ff, lvl_in;
   logic [MA_W-1:0]   tbl_ff, tbl_in;     // word address of current table
   logic [WORD_W-1:0] ent_ff, ent_in;     // entry being linked
   logic [MA_W-1:0]   ptr_ff, ptr_in;     // clear sweep pointer
   logic [IDX_W-1:0]  cnt9_ff, cnt9_in;
   logic [CNT_W-1:0]  sc_ff, sc_in;

   // Output register.
   logic              rv_ff, rv_in;
   logic [2:0]        rs_ff, rs_in;
   logic [ADDR_W-1:0] rf_ff, rf_in;
   logic [WORD_W-1:0] rd_ff, rd_in;

   // Memories.
   logic              st_we;
   logic [SP_W-1:0]   st_addr;
   logic [ADDR_W-1:0] st_wd, st_rd;
   logic              tm_we;
   logic [MA_W-1:0]   tm_addr;
   logic [WORD_W-1:0] tm_wd, tm_rd;

   ptm_ram #(.WIDTH(ADDR_W), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .wr_en(st_we), .addr(st_addr), .wr_data(st_wd), .rd_data(st_rd));
   ptm_ram #(.WIDTH(WORD_W), .DEPTH(MEM_WORDS)) u_table (
      .clock(clock), .wr_en(tm_we), .addr(tm_addr), .wr_data(tm_wd), .rd_data(tm_rd));

   logic              accept;
   logic [IDX_W-1:0]  idx;
   logic [WORD_W-1:0] cache;
   logic [WORD_W-1:0] new_ent;

   assign req_stall = (state_ff != S_IDLE) || rv_ff;
   assign accept    = req_valid && !req_stall;
   assign cache     = flags_ff & CACHE_BITS;

   // Entry index for the current level: bits 47:39, 38:30, 29:21, 20:12.
   always_comb begin
      unique case (lvl_ff)
         2'd0:    idx = va_ff[47:39];
         2'd1:    idx = va_ff[38:30];
         2'd2:    idx = va_ff[29:21];
         default: idx = va_ff[20:12];
      endcase
   end

   assign new_ent = {{(WORD_W-ADDR_W){1'b0}}, st_rd} | BIT_P | BIT_RW | cache;

   always_comb begin
      state_in = state_ff;
      lvl_in   = lvl_ff;
      tbl_in   = tbl_ff;
      ent_in   = ent_ff;
      ptr_in   = ptr_ff;
      cnt9_in  = cnt9_ff;
      sc_in    = sc_ff;
      rv_in    = rv_ff && rsp_stall;
      rs_in    = rs_ff;
      rf_in    = rf_ff;
      rd_in    = rd_ff;
      st_we    = 1'b0;
      st_addr  = sc_ff[SP_W-1:0];
      st_wd    = req_phys_addr;
      tm_we    = 1'b0;
      tm_addr  = tbl_ff + MA_W'(idx);
      tm_wd    = ent_ff;
      unique case (state_ff)
         S_INIT: begin
            // Sweep the table memory to zero after reset.
            tm_we   = 1'b1;
            tm_addr = ptr_ff;
            tm_wd   = '0;
            ptr_in  = ptr_ff + 1'b1;
            if (ptr_ff == MA_W'(MEM_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            tm_addr = req_phys_addr[MA_W+2:3];
            if (accept) begin
               lvl_in = '0;
               tbl_in = {root_ff[MA_W+2:12], {IDX_W{1'b0}}};
               unique case (kind_type'(req_kind))
                  KIND_FREE: begin
                     if (sc_ff < CNT_MAX) begin
                        st_we = 1'b1;
                        sc_in = sc_ff + 1'b1;
                        rs_in = ST_OK;
                     end else begin
                        rs_in = ST_FULL;
                     end
                     rf_in = '0; rd_in = '0; rv_in = 1'b1;
                  end
                  KIND_ALLOC: begin
                     rd_in = '0;
                     if (sc_ff == '0) begin
                        rs_in = ST_NO_FRAME; rf_in = '0; rv_in = 1'b1;
                     end else begin
                        sc_in = sc_ff - 1'b1;
                        state_in = S_POP;
                     end
                  end
                  KIND_MAP:  state_in = S_ELOOK;
                  KIND_READ: state_in = S_RDW;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_POP: begin
            state_in = S_POPW;   // stack read in flight
         end
         S_POPW: begin
            rs_in = ST_OK; rf_in = st_rd; rv_in = 1'b1;
            state_in = S_IDLE;
         end
         S_RDW: begin
            rs_in = ST_OK; rf_in = '0; rd_in = tm_rd; rv_in = 1'b1;
            state_in = S_IDLE;
         end
         S_ELOOK: begin
            // Read the entry; pop a frame speculatively only if used later.
            st_addr  = SP_W'(sc_ff - 1'b1);
            state_in = (lvl_ff == 2'd3) ? S_LEAF : S_EWAIT;
         end
         S_EWAIT: begin
            st_addr  = SP_W'(sc_ff - 1'b1);
            state_in = S_EDEC;
         end
         S_EDEC: begin
            st_addr = SP_W'(sc_ff - 1'b1);
            if (tm_rd[0]) begin
               tm_we    = 1'b1;
               tm_wd    = tm_rd | cache;
               tbl_in   = {tm_rd[MA_W+2:12], {IDX_W{1'b0}}};
               lvl_in   = lvl_ff + 1'b1;
               state_in = S_ELOOK;
            end else if (sc_ff == '0) begin
               rs_in = status_type'(3'(ST_NO_L3) + 3'(lvl_ff));
               rf_in = '0; rd_in = '0; rv_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               // Link the popped frame now, then clear it.
               tm_we    = 1'b1;
               tm_wd    = new_ent;
               ent_in   = new_ent;
               sc_in    = sc_ff - 1'b1;
               ptr_in   = {st_rd[MA_W+2:12], {IDX_W{1'b0}}};
               cnt9_in  = '0;
               state_in = S_CLEAR;
            end
         end
         S_CLEAR: begin
            tm_we   = 1'b1;
            tm_addr = ptr_ff;
            tm_wd   = '0;
            ptr_in  = ptr_ff + 1'b1;
            cnt9_in = cnt9_ff + 1'b1;
            if (cnt9_ff == '1) begin
               // Rewrite the link in case the cleared frame covered it.
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            tm_we    = 1'b1;
            tm_wd    = ent_ff;
            tbl_in   = {ent_ff[MA_W+2:12], {IDX_W{1'b0}}};
            lvl_in   = lvl_ff + 1'b1;
            state_in = S_ELOOK;
         end
         S_LEAF: begin
            tm_we = 1'b1;
            tm_wd = {{(WORD_W-ADDR_W){1'b0}}, pa_ff} | flags_ff;
            rs_in = ST_OK; rf_in = '0; rd_in = '0; rv_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         ptr_ff   <= '0;
         sc_ff    <= '0;
         rv_ff    <= 1'b0;
         lvl_ff   <= '0;
         cnt9_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         sc_ff    <= sc_in;
         rv_ff    <= rv_in;
         lvl_ff   <= lvl_in;
         cnt9_ff  <= cnt9_in;
      end
   end

   always_ff @(posedge clock) begin
      tbl_ff <= tbl_in;
      ent_ff <= ent_in;
      rs_ff  <= rs_in;
      rf_ff  <= rf_in;
      rd_ff  <= rd_in;
      if (accept) begin
         kind_ff  <= kind_type'(req_kind);
         pa_ff    <= req_phys_addr;
         va_ff    <= req_virt_addr;
         flags_ff <= req_page_flags;
      end
   end

   assign rsp_valid     = rv_ff;
   assign rsp_status    = rs_ff;
   assign rsp_frame_out = rf_ff;
   assign rsp_read_data = rd_ff;

   `PTM_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, sc_ff <= CNT_MAX, "stack count overflow")
   `PTM_ASSERT_IMPL(a_no_accept_busy, clock, reset, rv_ff, !accept, "item taken while beat waits")
   `PTM_ASSERT_NEXT(a_pop_done, clock, reset, state_ff == S_POPW && kind_ff == KIND_ALLOC, rv_ff && rs_ff == ST_OK, "alloc beat missing")
endmodule

// ===== tb/page_table_mapper_with_frame_stack_core_tb.sv =====
// -----------------------------------------------------------------------------
// Page table mapper testbench
// Drives free, allocate, map and read beats through the request channel and
// checks every response beat against a predictor of the frame stack and the
// table memory. The root table register is changed between phases.
// -----------------------------------------------------------------------------
module page_table_mapper_with_frame_stack_core_tb;
   import ptm_pkg::*;

   localparam int MEM_WORDS   = MEM_FRAMES_DEF * ENTRIES_PER_TABLE_DEF;
   localparam int WATCHDOG    = 600000;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      status_type         status;
      logic [ADDR_W-1:0]  frame;
      logic [WORD_W-1:0]  data;
   } rsp_beat_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   kind_type            req_kind = KIND_FREE;
   logic [ADDR_W-1:0]   req_phys_addr = '0;
   logic [WORD_W-1:0]   req_virt_addr = '0;
   logic [WORD_W-1:0]   req_page_flags = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [2:0]          rsp_status;
   logic [ADDR_W-1:0]   rsp_frame_out;
   logic [WORD_W-1:0]   rsp_read_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [ADDR_W-1:0]   csr_root_table_addr = '0;

   // Predictor state: frame stack, table memory and root register.
   logic [ADDR_W-1:0]   free_frames [STACK_DEPTH_DEF];
   int                  free_count = 0;
   logic [WORD_W-1:0]   table_words [MEM_WORDS];
   logic [ADDR_W-1:0]   root_addr = '0;
   logic [16:0]         last_leaf = '0;

   rsp_beat_type        pending_rsp [$];
   int                  mismatches = 0;
   int                  idle_cycles = 0;
   int                  send_idle_pct = 0;
   int                  rsp_stall_pct = 0;

   page_table_mapper_with_frame_stack_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_phys_addr       (req_phys_addr),
      .req_virt_addr       (req_virt_addr),
      .req_page_flags      (req_page_flags),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_frame_out       (rsp_frame_out),
      .rsp_read_data       (rsp_read_data),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_root_table_addr (csr_root_table_addr)
   );

   always #2 clock = ~clock;

   function automatic logic [WORD_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Word index of entry idx in the table at tbl; wraps within the memory.
   function automatic logic [16:0] entry_word(logic [WORD_W-1:0] tbl, int idx);
      logic [WORD_W-1:0] w;
      w = ((tbl & ADDR_FIELD) >> 3) + idx;
      return w[16:0];
   endfunction

   function automatic status_type walk_and_map(logic [ADDR_W-1:0] pa,
                                               logic [WORD_W-1:0] va,
                                               logic [WORD_W-1:0] flags);
      logic [WORD_W-1:0] cache;
      logic [WORD_W-1:0] tbl;
      logic [WORD_W-1:0] e;
      logic [WORD_W-1:0] f;
      logic [16:0]       w;
      cache = flags & CACHE_BITS;
      tbl   = {12'b0, root_addr} & ADDR_FIELD;
      for (int lvl = 0; lvl < 3; lvl++) begin
         w = entry_word(tbl, int'((va >> (39 - 9 * lvl)) & 64'h1FF));
         e = table_words[w];
         if (!e[0]) begin
            // Missing level: pop a frame, clear it and link it in.
            if (free_count == 0) return status_type'(ST_NO_L3 + lvl);
            free_count--;
            f = {12'b0, free_frames[free_count]};
            for (int i = 0; i < ENTRIES_PER_TABLE_DEF; i++)
               table_words[entry_word(f, i)] = '0;
            e = f | BIT_P | BIT_RW | cache;
         end else begin
            e = e | cache;
         end
         table_words[w] = e;
         tbl = e & ADDR_FIELD;
      end
      w = entry_word(tbl, int'(va[20:12]));
      table_words[w] = {12'b0, pa} | flags;
      last_leaf = w;
      return ST_OK;
   endfunction

   function automatic rsp_beat_type predict_mapper(kind_type kind, logic [ADDR_W-1:0] pa,
                                                   logic [WORD_W-1:0] va,
                                                   logic [WORD_W-1:0] flags);
      rsp_beat_type b;
      b.status = ST_OK;
      b.frame  = '0;
      b.data   = '0;
      case (kind)
         KIND_FREE: begin
            if (free_count < STACK_DEPTH_DEF) begin
               free_frames[free_count] = pa;
               free_count++;
            end else begin
               b.status = ST_FULL;
            end
         end
         KIND_ALLOC: begin
            if (free_count == 0) begin
               b.status = ST_NO_FRAME;
            end else begin
               free_count--;
               b.frame = free_frames[free_count];
            end
         end
         KIND_MAP: b.status = walk_and_map(pa, va, flags);
         default: b.data = table_words[pa[19:3]];
      endcase
      return b;
   endfunction

   // Send one request beat; valid stays high afterwards until the next call.
   task automatic send_item(kind_type kind, logic [ADDR_W-1:0] pa,
                            logic [WORD_W-1:0] va, logic [WORD_W-1:0] flags);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_phys_addr  <= pa;
      req_virt_addr  <= va;
      req_page_flags <= flags;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsp.push_back(predict_mapper(kind, pa, va, flags));
   endtask

   // Drop valid and wait until every response beat has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_root(logic [ADDR_W-1:0] value);
      csr_valid           <= 1'b1;
      csr_root_table_addr <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      root_addr = value;
      csr_valid <= 1'b0;
   endtask

   // Accept response beats and compare against the oldest prediction.
   always @(posedge clock) begin
      rsp_beat_type exp_b;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected response beat: status %0d", rsp_status);
         end else begin
            exp_b = pending_rsp.pop_front();
            if (rsp_status !== exp_b.status || rsp_frame_out !== exp_b.frame ||
                rsp_read_data !== exp_b.data) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("mismatch: exp st %0d fr %h rd %h, got st %0d fr %h rd %h",
                           exp_b.status, exp_b.frame, exp_b.data,
                           rsp_status, rsp_frame_out, rsp_read_data);
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Watchdog: count cycles in which no channel moves a beat.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Empty memory reads zero; allocate on an empty stack finds no frame.
   task automatic test_empty_state();
      send_item(KIND_READ, '0, '0, '0);
      send_item(KIND_READ, '1, '1, '1);
      send_item(KIND_ALLOC, '1, '0, '0);
   endtask

   // Map with no free frames aborts at each level in turn; frame zero is valid.
   task automatic test_map_abort();
      send_item(KIND_MAP, '1, '1, '1);
      send_item(KIND_FREE, '0, '0, '0);
      send_item(KIND_MAP, 52'h12345, 64'h0000_8080_4020_1000, 64'h18);
      send_item(KIND_FREE, 52'hF_FFFF_FFFF_F123, '0, '0);
      send_item(KIND_MAP, 52'h12345, 64'h0000_8080_4020_1000, 64'h8);
      send_item(KIND_READ, '0, '0, '0);
   endtask

   // Full walk with unaligned frames, then hit existing levels and read back.
   task automatic test_map_walk();
      send_item(KIND_FREE, 52'h0_0000_0030_0ABC, '0, '0);
      send_item(KIND_FREE, 52'hA_BCDE_F004_0007, '0, '0);
      send_item(KIND_FREE, 52'h0_0000_0005_0000, '0, '0);
      send_item(KIND_MAP, '1, '1, '1);
      send_item(KIND_READ, {32'h0, last_leaf, 3'h7}, '0, '0);
      send_item(KIND_MAP, 52'h5_5555_5555_5555, 64'hFFFF_FFFF_FFFF_E000, '0);
      send_item(KIND_READ, {32'hFFFFF, last_leaf, 3'h0}, '0, '0);
      send_item(KIND_ALLOC, '0, '0, '0);
      send_item(KIND_ALLOC, '0, '0, '0);
   endtask

   // Fill the stack past its depth, then pop a few frames back.
   task automatic test_stack_full();
      for (int i = 0; i <= STACK_DEPTH_DEF; i++)
         send_item(KIND_FREE, ADDR_W'(rand64()), '0, '0);
      for (int i = 0; i < 4; i++)
         send_item(KIND_ALLOC, '0, '0, '0);
   endtask

   task automatic test_random(int count, int mode, logic [ADDR_W-1:0] root);
      int r;
      logic [WORD_W-1:0] va;
      drain();
      write_root(root);
      case (mode)
         0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin send_idle_pct = 51; rsp_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  rsp_stall_pct = 51; end
         default: begin send_idle_pct = 38; rsp_stall_pct = 38; end
      endcase
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < 22) begin
            if ($urandom_range(1))
               send_item(KIND_FREE, ADDR_W'(rand64()), rand64(), rand64());
            else
               send_item(KIND_FREE, ADDR_W'((rand64() & 64'hFFFF_FFFF_FFF0_0000) |
                         {$urandom_range(255), 12'h0}), '0, '0);
         end else if (r < 34) begin
            send_item(KIND_ALLOC, ADDR_W'(rand64()), rand64(), rand64());
         end else if (r < 62) begin
            // Keep most walks in a small window so tables get reused.
            va = rand64();
            if ($urandom_range(99) < 85)
               va = {va[63:48], 7'h0, 2'($urandom), 7'h0, 2'($urandom),
                     7'h0, 2'($urandom), va[20:0]};
            send_item(KIND_MAP, ADDR_W'(rand64()), va, rand64());
         end else begin
            if ($urandom_range(99) < 60)
               send_item(KIND_READ, ADDR_W'((rand64() & 64'hFFFF_FFFF_FFF0_0000) |
                         {last_leaf, 3'($urandom)}), rand64(), rand64());
            else
               send_item(KIND_READ, ADDR_W'(rand64()), rand64(), rand64());
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      write_root(52'h0_0000_0000_2000);
      test_empty_state();
      test_map_abort();
      test_map_walk();
      test_stack_full();
      test_random(345, 0, '0);
      test_random(345, 1, '1);
      test_random(345, 2, ADDR_W'(rand64()));
      test_random(345, 3, 52'h0_0000_0001_0FFF);
      drain();
      repeat (50) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== page_table_mapper_with_frame_stack_core.f =====
+incdir+design
design/ptm_pkg.sv
design/ptm_ram.sv
design/page_table_mapper_with_frame_stack_core.sv
tb/page_table_mapper_with_frame_stack_core_tb.sv
